[design/rmsi_pkg.sv]
// Shared types and constants for the running median block.
`timescale 1ns / 1ps

package rmsi_pkg;

    localparam int CAPACITY_DEFAULT     = 256;
    localparam int SAMPLE_WIDTH_DEFAULT = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_PUT,
        ST_MED_HI,
        ST_MED_LO,
        ST_MED_SUM,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        RD_PREV,
        RD_MID_HI,
        RD_MID_LO
    } rd_sel_t;

    typedef enum logic {
        WR_FROM_RAM,
        WR_FROM_SAMPLE
    } wr_sel_t;

    typedef struct packed {
        logic    load_sample;
        logic    k_dec;
        rd_sel_t rd_sel;
        logic    wr_en;
        wr_sel_t wr_sel;
        logic    cnt_inc;
        logic    cap_a;
        logic    cap_median;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic k_is_one;
        logic greater;
    } status_t;

endpackage

[design/running_median_sorted_insert.sv]
// Top level of the running median block: controller plus datapath.
`timescale 1ns / 1ps
//
// Running median over the samples held since reset, kept in a sorted store.
// Input channel: s_valid/s_ready with s_sample, one signed sample per transaction.
// Output channel: m_valid/m_ready with m_median_twice (twice the median, one
// fractional bit), m_held_count (samples held) and m_dropped (store was full).
// Every input transaction yields exactly one output transaction.
// Insertion walks the store from its top entry down through the single RAM read
// port, each entry moved in a read, then a compare and write back one slot up.
// A new sample is taken only once the result of the previous one has loaded into
// the output register, so the walk sets the throughput. The RAM read port also
// sets the median step: two reads for the middle entries.
// Reset empties the store (fill count to zero), clears m_valid and returns the
// controller to idle; the RAM contents are not cleared, since only entries below
// the fill count are used.
// When the receiver stalls, hold the result in the output register; a next sample
// is still accepted and processed, and waits in the done state until the output
// register frees up. Once CAPACITY samples are held, drop every further sample
// and repeat the last median with m_dropped set.
//
module running_median_sorted_insert #(
    parameter int CAPACITY     = rmsi_pkg::CAPACITY_DEFAULT,
    parameter int SAMPLE_WIDTH = rmsi_pkg::SAMPLE_WIDTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [SAMPLE_WIDTH-1:0]       s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [SAMPLE_WIDTH:0]         m_median_twice,
    output logic [$clog2(CAPACITY+1)-1:0] m_held_count,
    output logic                          m_dropped
);

    import rmsi_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    cmd_t    cmd;
    status_t status;

    // Sequence the work for one transaction at a time.
    rmsi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Store, pointer, count, median arithmetic and output register.
    rmsi_datapath #(
        .CAPACITY     (CAPACITY),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .CW           (CW)
    ) u_datapath (
        .aclk           (aclk),
        .cmd            (cmd),
        .status         (status),
        .s_sample       (s_sample),
        .m_median_twice (m_median_twice),
        .m_held_count   (m_held_count),
        .m_dropped      (m_dropped),
        .aresetn        (aresetn)
    );

endmodule

[design/rmsi_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module rmsi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[design/rmsi_datapath.sv]
// Datapath: sorted store, insertion pointer, fill count and median arithmetic.
`timescale 1ns / 1ps

module rmsi_datapath #(
    parameter int CAPACITY     = rmsi_pkg::CAPACITY_DEFAULT,
    parameter int SAMPLE_WIDTH = rmsi_pkg::SAMPLE_WIDTH_DEFAULT,
    parameter int CW           = $clog2(CAPACITY + 1)
) (
    input  logic                     aclk,
    input  rmsi_pkg::cmd_t           cmd,
    output rmsi_pkg::status_t        status,
    input  logic [SAMPLE_WIDTH-1:0]  s_sample,
    output logic [SAMPLE_WIDTH:0]    m_median_twice,
    output logic [CW-1:0]            m_held_count,
    output logic                     m_dropped,
    input  logic                     aresetn
);

    import rmsi_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CW-1:0] CAP_VAL = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE     = CW'(1);

    logic [SAMPLE_WIDTH-1:0] s_reg;
    logic [SAMPLE_WIDTH-1:0] a_reg;
    logic [SAMPLE_WIDTH:0]   median_reg;
    logic [SAMPLE_WIDTH:0]   median_next;
    logic [CW-1:0]           k_reg;
    logic [CW-1:0]           count_reg;
    logic                    drop_reg;
    logic [SAMPLE_WIDTH:0]   out_median_reg;
    logic [CW-1:0]           out_count_reg;
    logic                    out_drop_reg;

    logic [CW-1:0]           half;
    logic [CW-1:0]           rd_idx;
    logic [AW-1:0]           rd_addr;
    logic [AW-1:0]           wr_addr;
    logic [SAMPLE_WIDTH-1:0] wr_data;
    logic [SAMPLE_WIDTH-1:0] rd_data;

    assign half = count_reg >> 1;

    always_comb begin
        case (cmd.rd_sel)
            RD_PREV:   rd_idx = k_reg - ONE;
            RD_MID_HI: rd_idx = half;
            RD_MID_LO: rd_idx = half - ONE;
            default:   rd_idx = k_reg - ONE;
        endcase
    end

    assign rd_addr = rd_idx[AW-1:0];
    assign wr_addr = k_reg[AW-1:0];
    assign wr_data = (cmd.wr_sel == WR_FROM_SAMPLE) ? s_reg : rd_data;

    rmsi_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Odd count: twice the middle entry; even count: sum of the two middle entries.
    always_comb begin
        if (count_reg[0]) begin
            median_next = {a_reg, 1'b0};
        end else begin
            median_next = {a_reg[SAMPLE_WIDTH-1], a_reg} + {rd_data[SAMPLE_WIDTH-1], rd_data};
        end
    end

    assign status.full     = (count_reg == CAP_VAL);
    assign status.empty    = (count_reg == '0);
    assign status.k_is_one = (k_reg == ONE);
    assign status.greater  = ($signed(rd_data) > $signed(s_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.cnt_inc) begin
            count_reg <= count_reg + ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            s_reg    <= s_sample;
            k_reg    <= count_reg;
            drop_reg <= status.full;
        end else if (cmd.k_dec) begin
            k_reg <= k_reg - ONE;
        end
        if (cmd.cap_a) begin
            a_reg <= rd_data;
        end
        if (cmd.cap_median) begin
            median_reg <= median_next;
        end
        if (cmd.load_out) begin
            out_median_reg <= median_reg;
            out_count_reg  <= count_reg;
            out_drop_reg   <= drop_reg;
        end
    end

    assign m_median_twice = out_median_reg;
    assign m_held_count   = out_count_reg;
    assign m_dropped      = out_drop_reg;

endmodule

[design/rmsi_ctrl.sv]
// Controller: sequences insertion shifts, median reads and the result handshake.
`timescale 1ns / 1ps

module rmsi_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  rmsi_pkg::status_t status,
    output rmsi_pkg::cmd_t    cmd
);

    import rmsi_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        cmd.rd_sel   = RD_PREV;
        cmd.wr_sel   = WR_FROM_RAM;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_sample = 1'b1;
                    if (status.full) begin
                        state_next = ST_DONE;
                    end else if (status.empty) begin
                        state_next = ST_PUT;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                cmd.rd_sel = RD_PREV;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.wr_en = 1'b1;
                if (status.greater) begin
                    cmd.wr_sel = WR_FROM_RAM;
                    cmd.k_dec  = 1'b1;
                    state_next = status.k_is_one ? ST_PUT : ST_READ;
                end else begin
                    cmd.wr_sel  = WR_FROM_SAMPLE;
                    cmd.cnt_inc = 1'b1;
                    state_next  = ST_MED_HI;
                end
            end
            ST_PUT: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_FROM_SAMPLE;
                cmd.cnt_inc = 1'b1;
                state_next  = ST_MED_HI;
            end
            ST_MED_HI: begin
                cmd.rd_sel = RD_MID_HI;
                state_next = ST_MED_LO;
            end
            ST_MED_LO: begin
                cmd.cap_a  = 1'b1;
                cmd.rd_sel = RD_MID_LO;
                state_next = ST_MED_SUM;
            end
            ST_MED_SUM: begin
                cmd.cap_median = 1'b1;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule
